>>> hdl/cqs_pkg.sv
// cqs_pkg: types and codes shared by the circular queue with search.
// No dependencies.
`default_nettype none

package cqs_pkg;

  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_DEQ    = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] value_out;
    logic        [3:0]  position;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DEQ,
    S_SCAN,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic       scan_start;
    logic       scan_step;
    logic       enq_write;
    logic       deq_pop;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_data;
    logic       res_pos;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       full;
    logic       empty;
    logic       match;
    logic       last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/cqs_ctrl.sv
// cqs_ctrl: request sequencer for the circular queue.
// Depends on cqs_pkg; drives cqs_dp through cmd_t, watches sts_t.
`default_nettype none

module cqs_ctrl (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_stall,
  input  wire cqs_pkg::sts_t sts,
  output cqs_pkg::cmd_t cmd
);
  import cqs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.req_type)
          REQ_DEQ: begin
            state_nxt = sts.empty ? S_REPLY : S_DEQ;
          end
          REQ_SEARCH: begin
            state_nxt = sts.empty ? S_REPLY : S_SCAN;
          end
          default: begin
            state_nxt = S_REPLY;
          end
        endcase
      end
      S_DEQ: begin
        state_nxt = S_REPLY;
      end
      S_SCAN: begin
        if (sts.match || sts.last) state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
      end
      S_DECODE: begin
        unique case (sts.req_type)
          REQ_ENQ: begin
            cmd.res_load = 1'b1;
            if (sts.full) begin
              cmd.res_status = STAT_FULL;
            end else begin
              cmd.enq_write  = 1'b1;
              cmd.res_status = STAT_OK;
            end
          end
          REQ_DEQ: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_EMPTY;
            end else begin
              cmd.rd_en = 1'b1;
            end
          end
          REQ_SEARCH: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_EMPTY;
            end else begin
              cmd.rd_en      = 1'b1;
              cmd.scan_start = 1'b1;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_OK;
          end
        endcase
      end
      S_DEQ: begin
        cmd.deq_pop    = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = STAT_OK;
        cmd.res_data   = 1'b1;
      end
      S_SCAN: begin
        priority if (sts.match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_OK;
          cmd.res_pos    = 1'b1;
        end else if (sts.last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_NOTFOUND;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.scan_step = 1'b1;
        end
      end
      S_REPLY: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/cqs_dp.sv
// cqs_dp: slot memory, head/tail/occupancy, scan counter and output register.
// Depends on cqs_pkg; commanded by cqs_ctrl.
`default_nettype none

module cqs_dp #(
  parameter int DEPTH = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire cqs_pkg::in_item_t in_item,
  input  wire cqs_pkg::cmd_t     cmd,
  output cqs_pkg::sts_t     sts,
  output logic              out_valid,
  input  wire               out_stall,
  output cqs_pkg::out_item_t out_item
);
  import cqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW + 1 > 4) ? CW + 1 : 4;

  logic signed [31:0] mem [DEPTH];

  in_item_t           req_r;
  logic [AW-1:0]      head_r, tail_r, scan_idx_r;
  logic [CW-1:0]      occ_r, scan_k_r;
  logic signed [31:0] rd_data_r;
  logic [1:0]         res_status_r;
  logic signed [31:0] res_vout_r;
  logic [3:0]         res_pos_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [AW-1:0]      head_wrap, tail_wrap, scan_wrap, rd_addr;
  logic [PW-1:0]      pos_wide;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  assign head_wrap = wrap_inc(head_r);
  assign tail_wrap = wrap_inc(tail_r);
  assign scan_wrap = wrap_inc(scan_idx_r);
  assign rd_addr   = cmd.scan_step ? scan_wrap : head_r;
  assign pos_wide  = PW'(scan_k_r) + PW'(1);

  always_comb begin
    sts.req_type = req_r.req_type;
    sts.full     = (occ_r == CW'(DEPTH));
    sts.empty    = (occ_r == '0);
    sts.match    = (rd_data_r == req_r.value_in);
    sts.last     = (pos_wide == PW'(occ_r));
    sts.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_write) mem[tail_r] <= req_r.value_in;
    if (cmd.rd_en)     rd_data_r   <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) req_r <= in_item;
    if (cmd.scan_start) begin
      scan_idx_r <= head_r;
      scan_k_r   <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_wrap;
      scan_k_r   <= scan_k_r + CW'(1);
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_vout_r   <= cmd.res_data ? rd_data_r : 32'sd0;
      res_pos_r    <= cmd.res_pos ? pos_wide[3:0] : 4'd0;
    end
    if (cmd.out_load) begin
      out_item_r.status    <= res_status_r;
      out_item_r.value_out <= res_vout_r;
      out_item_r.position  <= res_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.enq_write) begin
        tail_r <= tail_wrap;
        occ_r  <= occ_r + CW'(1);
      end else if (cmd.deq_pop) begin
        head_r <= head_wrap;
        occ_r  <= occ_r - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> hdl/circular_queue_with_search.sv
// Circular FIFO of signed words with enqueue, dequeue and key search.
// One request in flight. A search reads n entries through the single slot memory
// read port (n = match position, or occupancy on a miss). The next beat is
// accepted in the cycle after the result loads into the output register.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
`default_nettype none

module circular_queue_with_search #(
  parameter int DEPTH = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire cqs_pkg::in_item_t in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output cqs_pkg::out_item_t  out_item
);
  import cqs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> hdl/cqs_checker.sv
// cqs_checker: port-level assertions for circular_queue_with_search.
// Depends on cqs_pkg; bound to the top level below.
`default_nettype none

module cqs_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input wire cqs_pkg::out_item_t out_item
);
  import cqs_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat accepted while previous one still in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output beat changed");

  a_pos_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != STAT_OK |-> out_item.position == 4'd0)
    else $error("position set on failed request");

  a_value_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.value_out != 32'sd0 |->
      out_item.status == STAT_OK && out_item.position == 4'd0)
    else $error("dequeue value together with status or position");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (.*);

`default_nettype wire
